// ===== sv/jetp_pkg.sv =====
package jetp_pkg;

    localparam int PIX_W     = 10;
    localparam int COUNT_W   = 12;
    localparam int COLOUR_W  = 24;
    localparam int C_W       = 30;
    localparam int Q_W       = 32;
    localparam int PROD_W    = 2 * Q_W;
    localparam int WIDE_W    = 40;
    localparam int FRAC_BITS = 27;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    localparam int DIV_NUM_W  = COUNT_W + COLOUR_W;
    localparam int DIV_DEN_W  = COUNT_W;
    localparam int DIV_STEPS  = DIV_NUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    // start point offset pixel * 2^29 / size through a constant reciprocal
    localparam int START_NUM_W = PIX_W + FRAC_BITS + 2;
    localparam int RECIP_SHIFT = 2 * PIX_W;
    localparam int RECIP_W     = START_NUM_W + PIX_W;
    localparam int RECIP_LO_W  = 25;
    localparam int RECIP_HI_W  = RECIP_W - RECIP_LO_W;
    localparam int START_SUM_W = PIX_W + RECIP_W;

    localparam int DEFAULT_IMAGE_WIDTH  = 800;
    localparam int DEFAULT_IMAGE_HEIGHT = 600;

    localparam logic signed [C_W-1:0]   C_REAL_RESET = -30'sd107374182;
    localparam logic signed [C_W-1:0]   C_IMAG_RESET = 30'sd105830072;
    localparam logic        [COUNT_W-1:0] LIMIT_RESET = 12'd240;

    localparam logic [CFG_IDX_W-1:0] REG_C_REAL     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_C_IMAG     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 2'd2;

    typedef struct packed {
        logic load_pixel;
        logic z_load;
        logic div_load;
        logic div_step;
        logic mul_en;
        logic upd_en;
        logic out_load;
    } jetp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic at_limit;
        logic escaped;
    } jetp_status_t;

endpackage

// ===== sv/jetp_ctrl.sv =====
module jetp_ctrl
    import jetp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  jetp_status_t status,
    output jetp_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_UPD    = 3'd3;
    localparam logic [2:0] S_COLOUR = 3'd4;
    localparam logic [2:0] S_DIVC   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_pixel = 1'b1;
                    state_next     = S_START;
                end
            end
            S_START: begin
                cmd.z_load = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                if (status.at_limit) begin
                    state_next = S_COLOUR;
                end else begin
                    cmd.mul_en = 1'b1;
                    state_next = S_UPD;
                end
            end
            S_UPD: begin
                if (status.escaped) begin
                    state_next = S_COLOUR;
                end else begin
                    cmd.upd_en = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_COLOUR: begin
                if (status.at_limit) begin
                    state_next = S_DONE;
                end else begin
                    cmd.div_load = 1'b1;
                    state_next   = S_DIVC;
                end
            end
            S_DIVC: begin
                if (status.div_done) begin
                    state_next = S_DONE;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== sv/jetp_datapath.sv =====
module jetp_datapath
    import jetp_pkg::*;
#(
    parameter int IMAGE_WIDTH  = DEFAULT_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = DEFAULT_IMAGE_HEIGHT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  jetp_cmd_t                  cmd,
    output jetp_status_t               status,
    input  logic        [PIX_W-1:0]    pixel_x,
    input  logic        [PIX_W-1:0]    pixel_y,
    input  logic signed [C_W-1:0]      c_real,
    input  logic signed [C_W-1:0]      c_imag,
    input  logic        [COUNT_W-1:0]  iteration_limit,
    output logic        [COUNT_W-1:0]  escape_count,
    output logic        [COLOUR_W-1:0] pixel_colour
);

    localparam int LO_PROD_W = PIX_W + RECIP_LO_W;
    localparam int HI_PROD_W = PIX_W + RECIP_HI_W;

    localparam logic signed [WIDE_W-1:0] Q_MAX_W = 40'sd2147483647;
    localparam logic signed [WIDE_W-1:0] Q_MIN_W = -40'sd2147483648;
    localparam logic signed [WIDE_W-1:0] START_OFS = 40'sd268435456;
    localparam logic [PROD_W-1:0]        ESCAPE_BOUND = 64'h0100_0000_0000_0000;

    // ceil(2^RECIP_W / size); the product shifted down by RECIP_SHIFT is exact
    localparam logic [RECIP_W-1:0] RECIP_X =
        RECIP_W'(((64'd1 << RECIP_W) + 64'(IMAGE_WIDTH) - 64'd1) / 64'(IMAGE_WIDTH));
    localparam logic [RECIP_W-1:0] RECIP_Y =
        RECIP_W'(((64'd1 << RECIP_W) + 64'(IMAGE_HEIGHT) - 64'd1) / 64'(IMAGE_HEIGHT));
    localparam logic [RECIP_LO_W-1:0] RECIP_X_LO = RECIP_X[RECIP_LO_W-1:0];
    localparam logic [RECIP_HI_W-1:0] RECIP_X_HI = RECIP_X[RECIP_W-1:RECIP_LO_W];
    localparam logic [RECIP_LO_W-1:0] RECIP_Y_LO = RECIP_Y[RECIP_LO_W-1:0];
    localparam logic [RECIP_HI_W-1:0] RECIP_Y_HI = RECIP_Y[RECIP_W-1:RECIP_LO_W];

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > Q_MAX_W) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < Q_MIN_W) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

    logic        [LO_PROD_W-1:0] x_lo_reg, y_lo_reg;
    logic        [HI_PROD_W-1:0] x_hi_reg, y_hi_reg;
    logic        [DIV_NUM_W-1:0] num_reg;
    logic        [DIV_DEN_W-1:0] rem_reg;
    logic        [DIV_DEN_W-1:0] den_reg;
    logic        [DIV_CNT_W-1:0] dcnt_reg;
    logic signed [Q_W-1:0]       zr_reg, zi_reg;
    logic signed [PROD_W-1:0]    rr_reg, ii_reg, ri_reg;
    logic        [COUNT_W-1:0]   j_reg;
    logic        [COUNT_W-1:0]   count_out_reg;
    logic        [COLOUR_W-1:0]  colour_out_reg;

    logic        [DIV_DEN_W:0]   trial;
    logic        [DIV_DEN_W:0]   trial_sub;
    logic                        trial_ge;
    logic        [DIV_NUM_W-1:0] colour_num;
    logic        [START_SUM_W-1:0] x_sum, y_sum;
    logic signed [WIDE_W-1:0]    start_x_wide, start_y_wide;
    logic        [PROD_W-1:0]    mag;
    logic signed [PROD_W-1:0]    diff_sq;
    logic signed [PROD_W-1:0]    sh_r, sh_i;
    logic signed [WIDE_W-1:0]    nr_wide, ni_wide;

    // restoring divider, one quotient bit per step
    assign trial     = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign trial_ge  = (trial >= {1'b0, den_reg});
    assign trial_sub = trial - {1'b0, den_reg};

    // j * 0xFFFFFF
    assign colour_num = {j_reg, {COLOUR_W{1'b0}}} - DIV_NUM_W'(j_reg);

    assign x_sum = (START_SUM_W'(x_hi_reg) << RECIP_LO_W) + START_SUM_W'(x_lo_reg);
    assign y_sum = (START_SUM_W'(y_hi_reg) << RECIP_LO_W) + START_SUM_W'(y_lo_reg);
    assign start_x_wide = $signed({1'b0, x_sum[START_SUM_W-1:RECIP_SHIFT]}) - START_OFS;
    assign start_y_wide = $signed({1'b0, y_sum[START_SUM_W-1:RECIP_SHIFT]}) - START_OFS;

    assign mag     = $unsigned(rr_reg) + $unsigned(ii_reg);
    assign diff_sq = rr_reg - ii_reg;
    assign sh_r    = diff_sq >>> FRAC_BITS;
    assign sh_i    = ri_reg >>> (FRAC_BITS - 1);
    assign nr_wide = WIDE_W'(sh_r) + WIDE_W'(c_real);
    assign ni_wide = WIDE_W'(sh_i) + WIDE_W'(c_imag);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
            j_reg    <= '0;
        end else begin
            if (cmd.div_load) begin
                dcnt_reg <= '0;
            end else if (cmd.div_step) begin
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            if (cmd.load_pixel) begin
                j_reg <= '0;
            end else if (cmd.upd_en) begin
                j_reg <= j_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_pixel) begin
            x_lo_reg <= LO_PROD_W'(pixel_x) * LO_PROD_W'(RECIP_X_LO);
            x_hi_reg <= HI_PROD_W'(pixel_x) * HI_PROD_W'(RECIP_X_HI);
            y_lo_reg <= LO_PROD_W'(pixel_y) * LO_PROD_W'(RECIP_Y_LO);
            y_hi_reg <= HI_PROD_W'(pixel_y) * HI_PROD_W'(RECIP_Y_HI);
        end
        if (cmd.div_load) begin
            num_reg <= colour_num;
            den_reg <= iteration_limit;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            num_reg <= {num_reg[DIV_NUM_W-2:0], trial_ge};
            rem_reg <= trial_ge ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        end
        if (cmd.z_load) begin
            zr_reg <= sat_q(start_x_wide);
            zi_reg <= sat_q(start_y_wide);
        end else if (cmd.upd_en) begin
            zr_reg <= sat_q(nr_wide);
            zi_reg <= sat_q(ni_wide);
        end
        if (cmd.mul_en) begin
            rr_reg <= PROD_W'(zr_reg) * PROD_W'(zr_reg);
            ii_reg <= PROD_W'(zi_reg) * PROD_W'(zi_reg);
            ri_reg <= PROD_W'(zr_reg) * PROD_W'(zi_reg);
        end
        if (cmd.out_load) begin
            count_out_reg  <= j_reg;
            colour_out_reg <= status.at_limit ? '0 : num_reg[COLOUR_W-1:0];
        end
    end

    assign status.div_done = (dcnt_reg == DIV_CNT_W'(DIV_STEPS));
    assign status.at_limit = (j_reg == iteration_limit);
    assign status.escaped  = (mag > ESCAPE_BOUND);

    assign escape_count = count_out_reg;
    assign pixel_colour = colour_out_reg;

endmodule

// ===== sv/julia_escape_time_pixel.sv =====
// Julia set escape-time evaluator, one pixel per transfer. The pixel is mapped to
// z0 = (-2 + 4x/IMAGE_WIDTH, -2 + 4y/IMAGE_HEIGHT) in Q5.27, then z = z^2 + c runs
// until |z|^2 > 4 or iteration_limit is reached; the result carries the count and
// colour = count*0xFFFFFF/limit (0 when the point stayed inside). One item is in
// flight at a time. Each iteration runs the square-and-add loop (three 32x32
// multipliers, then update); an escaping point then runs a 36-step bit-serial
// divider for the colour. The start point comes from a constant reciprocal
// multiply. A finished result waits in the output register while the next pixel
// is accepted. c_real, c_imag and iteration_limit are written through the cfg
// port; the user must do so between pixels, as the block does not enforce it.
module julia_escape_time_pixel
    import jetp_pkg::*;
#(
    parameter int IMAGE_WIDTH  = DEFAULT_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = DEFAULT_IMAGE_HEIGHT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // pixel_x[9:0], pixel_y[19:10], zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // escape_count[11:0], pixel_colour[35:12], pad
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [C_W-1:0]       cfg_wr_data
);

    logic signed [C_W-1:0]      c_real_reg, c_imag_reg;
    logic        [COUNT_W-1:0]  limit_reg;
    jetp_cmd_t                  cmd;
    jetp_status_t               status;
    logic        [COUNT_W-1:0]  escape_count;
    logic        [COLOUR_W-1:0] pixel_colour;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_real_reg <= C_REAL_RESET;
            c_imag_reg <= C_IMAG_RESET;
            limit_reg  <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_C_REAL:     c_real_reg <= $signed(cfg_wr_data);
                REG_C_IMAG:     c_imag_reg <= $signed(cfg_wr_data);
                REG_ITER_LIMIT: limit_reg  <= cfg_wr_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    jetp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    jetp_datapath #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .pixel_x         (s_tdata[PIX_W-1:0]),
        .pixel_y         (s_tdata[2*PIX_W-1:PIX_W]),
        .c_real          (c_real_reg),
        .c_imag          (c_imag_reg),
        .iteration_limit (limit_reg),
        .escape_count    (escape_count),
        .pixel_colour    (pixel_colour)
    );

    assign m_tdata = {{(M_TDATA_W - COUNT_W - COLOUR_W){1'b0}}, pixel_colour, escape_count};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (escape_count <= limit_reg))
        else $error("escape_count above iteration limit");

    a_inside_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (escape_count == limit_reg)) |-> (pixel_colour == '0))
        else $error("non-zero colour for a point that did not escape");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a pixel is in progress");
`endif

endmodule

// ===== tb/sv/julia_escape_time_pixel_tb.sv =====
module julia_escape_time_pixel_tb;
    import jetp_pkg::*;

    localparam int IMG_W = DEFAULT_IMAGE_WIDTH;
    localparam int IMG_H = DEFAULT_IMAGE_HEIGHT;
    localparam longint Q_HI = 64'sd2147483647;
    localparam longint Q_LO = -64'sd2147483648;

    typedef struct {
        logic [PIX_W-1:0]    px;
        logic [PIX_W-1:0]    py;
        logic [COUNT_W-1:0]  count;
        logic [COLOUR_W-1:0] colour;
    } pixel_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [C_W-1:0]       cfg_wr_data;

    // register mirror
    logic signed [C_W-1:0] c_real_now = C_REAL_RESET;
    logic signed [C_W-1:0] c_imag_now = C_IMAG_RESET;
    logic [COUNT_W-1:0]    limit_now  = LIMIT_RESET;

    pixel_result_t expected_pixels[$];
    pixel_result_t head;

    int errors       = 0;
    int pixels_sent  = 0;
    int pixels_done  = 0;
    int cfg_settings = 0;
    bit gaps_on      = 1'b1;
    bit stalls_on    = 1'b1;
    int hold_req     = 0;
    int hold_left    = 0;
    int stall_left   = 0;

    julia_escape_time_pixel DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint clamp_q(input longint v);
        if (v > Q_HI) return Q_HI;
        if (v < Q_LO) return Q_LO;
        return v;
    endfunction

    function automatic longint start_coord(input logic [PIX_W-1:0] pix, input int size);
        longint off;
        off = (longint'(pix) << (FRAC_BITS + 2)) / size;
        return clamp_q(off - (64'sd2 <<< FRAC_BITS));
    endfunction

    // escape-time iteration at Q5.27 with full-width products
    function automatic void escape_time(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py,
                                        output logic [COUNT_W-1:0] count,
                                        output logic [COLOUR_W-1:0] colour);
        longint zr;
        longint zi;
        longint rr;
        longint ii;
        longint nr;
        longint ni;
        longint unsigned mag;
        longint n;
        zr = start_coord(px, IMG_W);
        zi = start_coord(py, IMG_H);
        n = 0;
        while (n < longint'(limit_now)) begin
            rr = zr * zr;
            ii = zi * zi;
            mag = 64'(unsigned'(rr)) + 64'(unsigned'(ii));
            if (mag > (64'd4 << (2 * FRAC_BITS)))
                break;
            nr = clamp_q(((rr - ii) >>> FRAC_BITS) + longint'(c_real_now));
            ni = clamp_q(((zr * zi) >>> (FRAC_BITS - 1)) + longint'(c_imag_now));
            zr = nr;
            zi = ni;
            n++;
        end
        count = n[COUNT_W-1:0];
        if (n != longint'(limit_now))
            colour = COLOUR_W'((n * 64'hFFFFFF) / longint'(limit_now));
        else
            colour = '0;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 30)
            $display("MISMATCH: %s", what);
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 80);
        return $urandom_range(1, 3);
    endfunction

    // result side: random stalls, plus a long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_req > 0) begin
                hold_left = hold_req - 1;
                hold_req = 0;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (stalls_on && $urandom_range(0, 4) == 0) begin
                stall_left = pick_gap() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending, tdata %h", m_tdata));
            end else begin
                head = expected_pixels.pop_front();
                pixels_done++;
                if (m_tdata[COUNT_W-1:0] !== head.count)
                    report_mismatch($sformatf("pixel (%0d,%0d) escape_count %0d, want %0d",
                        head.px, head.py, m_tdata[COUNT_W-1:0], head.count));
                if (m_tdata[COUNT_W+COLOUR_W-1:COUNT_W] !== head.colour)
                    report_mismatch($sformatf("pixel (%0d,%0d) pixel_colour %h, want %h",
                        head.px, head.py, m_tdata[COUNT_W+COLOUR_W-1:COUNT_W], head.colour));
            end
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
        pixel_result_t e;
        int gap;
        gap = (gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_TDATA_W - 2 * PIX_W){1'b0}}, py, px};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        e.px = px;
        e.py = py;
        escape_time(px, py, e.count, e.colour);
        expected_pixels.push_back(e);
        pixels_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
    endtask

    task automatic set_config(input logic signed [C_W-1:0] cr, input logic signed [C_W-1:0] ci,
                              input logic [COUNT_W-1:0] lim);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_C_REAL;
        cfg_wr_data <= cr;
        @(posedge aclk);
        cfg_index <= REG_C_IMAG;
        cfg_wr_data <= ci;
        @(posedge aclk);
        cfg_index <= REG_ITER_LIMIT;
        cfg_wr_data <= {{(C_W - COUNT_W){1'b0}}, lim};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        c_real_now = cr;
        c_imag_now = ci;
        limit_now = lim;
        cfg_settings++;
    endtask

    task automatic pick_pixel(output logic [PIX_W-1:0] px, output logic [PIX_W-1:0] py);
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 10) begin
            px = $urandom_range(150, 650);
            py = $urandom_range(112, 488);
        end else if (sel < 17) begin
            px = $urandom_range(0, IMG_W - 1);
            py = $urandom_range(0, IMG_H - 1);
        end else begin
            px = $urandom_range(0, 1023);
            py = $urandom_range(0, 1023);
        end
    endtask

    function automatic logic signed [C_W-1:0] random_c();
        return C_W'(int'($urandom_range(0, 536870912)) - 268435456);
    endfunction

    // constants as left by reset, image corners, outside points, bit patterns
    task automatic test_reset_values();
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd799, 10'd599);
        send_pixel(10'd800, 10'd600);
        send_pixel(10'd400, 10'd300);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd341, 10'd682);
        send_pixel(10'd682, 10'd341);
        send_pixel(10'd500, 10'd250);
        drain_results();
    endtask

    task automatic test_zero_limit();
        set_config(C_REAL_RESET, C_IMAG_RESET, 12'd0);
        send_pixel(10'd400, 10'd300);
        send_pixel(10'd0, 10'd0);
        drain_results();
    endtask

    task automatic test_single_iteration();
        set_config(C_REAL_RESET, C_IMAG_RESET, 12'd1);
        send_pixel(10'd400, 10'd300);
        send_pixel(10'd0, 10'd0);
        drain_results();
    endtask

    // c = 0: unit disc stays inside for the full limit
    task automatic test_max_limit();
        set_config('0, '0, 12'd4095);
        send_pixel(10'd400, 10'd300);
        send_pixel(10'd500, 10'd350);
        send_pixel(10'd700, 10'd300);
        drain_results();
    endtask

    task automatic test_constant_extremes();
        set_config(-30'sd268435456, 30'sd268435456, 12'd30);
        send_pixel(10'd400, 10'd300);
        send_pixel(10'd450, 10'd320);
        drain_results();
        set_config(30'sd268435456, -30'sd268435456, 12'd30);
        send_pixel(10'd400, 10'd300);
        send_pixel(10'd380, 10'd290);
        drain_results();
        set_config(-30'sd536870912, 30'sd536870911, 12'd30);
        send_pixel(10'd400, 10'd300);
        send_pixel(10'd420, 10'd310);
        drain_results();
        set_config(30'sd536870911, -30'sd536870912, 12'd30);
        send_pixel(10'd400, 10'd300);
        send_pixel(10'd390, 10'd280);
        drain_results();
    endtask

    // receiver holds off while pixels keep coming, so the input stalls
    task automatic test_output_backpressure();
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        set_config(C_REAL_RESET, C_IMAG_RESET, 12'd20);
        gaps_on = 1'b0;
        hold_req = 2000;
        for (int k = 0; k < 8; k++) begin
            pick_pixel(px, py);
            send_pixel(px, py);
        end
        drain_results();
        gaps_on = 1'b1;
    endtask

    task automatic test_back_to_back();
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        set_config(random_c(), random_c(), COUNT_W'($urandom_range(1, 16)));
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        for (int k = 0; k < 40; k++) begin
            pick_pixel(px, py);
            send_pixel(px, py);
        end
        drain_results();
        gaps_on = 1'b1;
        stalls_on = 1'b1;
    endtask

    task automatic test_random_frames();
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        for (int f = 0; f < 8; f++) begin
            if (f == 0)
                set_config(C_REAL_RESET, C_IMAG_RESET, LIMIT_RESET);
            else if (f % 3 == 0)
                set_config(random_c(), random_c(), 12'd240);
            else
                set_config(random_c(), random_c(), COUNT_W'($urandom_range(1, 100)));
            gaps_on = (f != 5);
            stalls_on = (f != 6);
            for (int k = 0; k < 80; k++) begin
                pick_pixel(px, py);
                send_pixel(px, py);
            end
            drain_results();
        end
        gaps_on = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wr_data = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_zero_limit();
        test_single_iteration();
        test_max_limit();
        test_constant_extremes();
        test_output_backpressure();
        test_back_to_back();
        test_random_frames();
        drain_results();
        repeat (300) @(posedge aclk);
        $display("summary: %0d pixels sent, %0d results checked, %0d register settings",
                 pixels_sent, pixels_done, cfg_settings);
        $display("summary: limits 0/1/20/30/240/4095 and random, c extremes, output hold-off");
        if (errors == 0 && expected_pixels.size() == 0)
            $display("julia_escape_time_pixel_tb: clean");
        else
            $display("julia_escape_time_pixel_tb: errors");
        $finish;
    end

    initial begin
        #4000000;
        $display("julia_escape_time_pixel_tb: errors");
        $finish;
    end

endmodule
